// ----- sv/lrfe_pkg.sv -----
// lrfe_pkg: sizes, codes and constant tables of the lidar ring feature extractor.
// Used by lidar_ring_feature_extractor; depends on nothing else.
`default_nettype none

package lrfe_pkg;

  localparam int RINGS          = 16;
  localparam int PTS_PER_RING   = 2048;
  localparam int GROUND_RINGS   = 6;
  localparam int COORD_BITS     = 20;

  localparam int PAIRS       = (GROUND_RINGS < RINGS ? GROUND_RINGS : RINGS) - 1;
  localparam int RING_W      = $clog2(RINGS);
  localparam int IDX_W       = $clog2(PTS_PER_RING);
  localparam int ADDR_W      = RING_W + IDX_W;
  localparam int STORE_DEPTH = RINGS * PTS_PER_RING;
  localparam int FILL_W      = IDX_W + 1;
  localparam int RCNT_W      = $clog2(RINGS + 1);

  localparam int CURV_W   = 48;
  localparam int SLOPE_W  = 16;
  localparam int DROP_W   = 16;
  localparam int PT_W     = 3 * COORD_BITS;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SUM_W    = COORD_BITS + 4;
  localparam int RSQ_W    = 2 * COORD_BITS;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ELEV_W   = RSQ_W + 32;
  localparam int GND_W    = 2 * DIFF_W + 34;

  localparam int CURV_SPAN  = 3;
  localparam int PICK_SKIP  = 5;
  localparam int ZERO_STEP  = 8;

  localparam logic [CURV_W-1:0]  EDGE_RESET  = CURV_W'(200000);
  localparam logic [CURV_W-1:0]  PLANE_RESET = CURV_W'(100000);
  localparam logic [SLOPE_W-1:0] SLOPE_RESET = SLOPE_W'(11556);

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_EDGE  = 2'd0;
  localparam logic [1:0] REG_PLANE = 2'd1;
  localparam logic [1:0] REG_SLOPE = 2'd2;

  // Drain phases; a result's class is its phase minus one.
  localparam logic [1:0] PH_NONE   = 2'd0;
  localparam logic [1:0] PH_GROUND = 2'd1;
  localparam logic [1:0] PH_EDGE   = 2'd2;
  localparam logic [1:0] PH_PLANE  = 2'd3;

  typedef enum logic [1:0] {
    LBL_FREE   = 2'd0,
    LBL_GROUND = 2'd1,
    LBL_EDGE   = 2'd2,
    LBL_PLANE  = 2'd3
  } label_t;

  // Square of round(tan(2n degrees) * 2^16), for n = 0 .. 9.
  function automatic logic [31:0] tan_sq(input logic [3:0] n);
    logic [31:0] v;
    case (n)
      4'd0:    v = 32'd0;
      4'd1:    v = 32'(2289 * 2289);
      4'd2:    v = 32'(4583 * 4583);
      4'd3:    v = 32'(6888 * 6888);
      4'd4:    v = 32'(9210 * 9210);
      4'd5:    v = 32'(11556 * 11556);
      4'd6:    v = 32'(13930 * 13930);
      4'd7:    v = 32'(16340 * 16340);
      4'd8:    v = 32'(18792 * 18792);
      4'd9:    v = 32'(21294 * 21294);
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- sv/lidar_ring_feature_extractor.sv -----
// lidar_ring_feature_extractor: ring binning, ground, curvature and feature selection.
// Depends on lrfe_pkg for sizes, codes and the tangent table.
`default_nettype none

// A load item (op 0) bins one point by elevation with a shared 32 x 32 multiplier
// that tests one ring boundary at a time. A load with frame_end then runs the
// frame passes over the point store, each step waiting on the single read port of
// the stores: a clearing pass of labels and pair flags at one cycle per stored
// point, a ground pass over the checked pairs, a curvature pass over the inner
// points and a selection pass over the visited points, followed by the search for
// the first result.
// A fetch item (op 1) reads one result and then, unless it is the upper point of
// a ground pair, searches forward for the next one. in_stall is high for as long
// as an item is at work; a finished result waits in the output register while the
// next item is taken.
module lidar_ring_feature_extractor (
  input  wire                              clk,
  input  wire                              rst_n,
  // input channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_op,
  input  wire signed [lrfe_pkg::COORD_BITS-1:0] in_x_mm,
  input  wire signed [lrfe_pkg::COORD_BITS-1:0] in_y_mm,
  input  wire signed [lrfe_pkg::COORD_BITS-1:0] in_z_mm,
  input  wire                              in_frame_end,
  // result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [1:0]                       out_point_class,
  output logic [lrfe_pkg::RING_W-1:0]      out_ring,
  output logic signed [lrfe_pkg::COORD_BITS-1:0] out_x_mm,
  output logic signed [lrfe_pkg::COORD_BITS-1:0] out_y_mm,
  output logic signed [lrfe_pkg::COORD_BITS-1:0] out_z_mm,
  output logic                             out_last_of_frame,
  output logic [lrfe_pkg::DROP_W-1:0]      out_dropped_points,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [4:0]                       paddr,
  input  wire  [63:0]                      pwdata,
  output logic [63:0]                      prdata,
  output logic                             pready
);
  import lrfe_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE, ST_EL_X, ST_EL_Y, ST_EL_Z, ST_EL_LO, ST_EL_HI, ST_EL_CMP, ST_LD_FIN,
    ST_CLR,
    ST_G_A, ST_G_B, ST_G_C, ST_G_D, ST_G_MX, ST_G_MY, ST_G_MZ, ST_G_GG,
    ST_G_H1, ST_G_H2, ST_G_CMP, ST_G_W2,
    ST_C_CHK, ST_C_A, ST_C_B, ST_C_C, ST_C_SX, ST_C_SY, ST_C_SZ, ST_C_W,
    ST_S_A, ST_S_B, ST_S_C,
    ST_SK_A, ST_SK_B, ST_SK_C,
    ST_F_B, ST_F_C, ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // Point being binned and the elevation unit's operands.
  logic signed [COORD_BITS-1:0] pt_x_r, pt_x_nxt, pt_y_r, pt_y_nxt, pt_z_r, pt_z_nxt;
  logic                         fe_r, fe_nxt;
  logic [PROD_W-1:0]            acc_r, acc_nxt;
  logic [RSQ_W-1:0]             rsq_r, rsq_nxt, az2_r, az2_nxt;
  logic [RCNT_W-1:0]            step_r, step_nxt;
  logic                         drop_flag_r, drop_flag_nxt;
  logic [RING_W-1:0]            ring_r, ring_nxt;

  // Frame bookkeeping.
  logic [FILL_W-1:0]            fill_r [RINGS];
  logic [FILL_W-1:0]            fill_nxt [RINGS];
  logic [DROP_W-1:0]            drop_cnt_r, drop_cnt_nxt;
  logic                         closed_r, closed_nxt;

  // Pass counters.
  logic [RCNT_W-1:0]            r_r, r_nxt;
  logic [FILL_W-1:0]            j_r, j_nxt;
  logic [2:0]                   k_r, k_nxt;

  // Ground pass operands.
  logic signed [COORD_BITS-1:0] hx_r, hx_nxt, hy_r, hy_nxt, hz_r, hz_nxt;
  logic [DIFF_W-1:0]            mx_r, mx_nxt, my_r, my_nxt, mz_r, mz_nxt;
  logic [2*DIFF_W-1:0]          h2_r, h2_nxt, mz2_r, mz2_nxt;
  logic [31:0]                  g2_r, g2_nxt;

  // Curvature sums.
  logic signed [SUM_W-1:0]      sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;

  // Drain position.
  logic [1:0]                   phase_r, phase_nxt;
  logic [RCNT_W-1:0]            dr_r, dr_nxt;
  logic [FILL_W-1:0]            di_r, di_nxt;
  logic                         ph_r, ph_nxt;
  logic                         seek_fetch_r, seek_fetch_nxt;

  // Result waiting to be moved to the output register.
  logic [1:0]                   res_cls_r, res_cls_nxt;
  logic [RING_W-1:0]            res_ring_r, res_ring_nxt;
  logic [PT_W-1:0]              res_pt_r, res_pt_nxt;
  logic [DROP_W-1:0]            res_drop_r, res_drop_nxt;

  // Output register.
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_cls_r, out_cls_nxt;
  logic [RING_W-1:0]            out_ring_r, out_ring_nxt;
  logic [PT_W-1:0]              out_pt_r, out_pt_nxt;
  logic                         out_last_r, out_last_nxt;
  logic [DROP_W-1:0]            out_drop_r, out_drop_nxt;

  // Configuration registers.
  logic [CURV_W-1:0]            edge_thr_r, plane_thr_r;
  logic [SLOPE_W-1:0]           slope_r;

  // Stores: one shared read address, read data registered.
  logic [PT_W-1:0]              pt_mem [STORE_DEPTH];
  label_t                       lb_mem [STORE_DEPTH];
  logic                         fl_mem [STORE_DEPTH];
  logic [CURV_W-1:0]            cv_mem [STORE_DEPTH];
  logic [ADDR_W-1:0]            rd_addr_r, rd_addr_nxt;
  logic [PT_W-1:0]              pd_r;
  label_t                       lb_rd_r;
  logic                         fl_rd_r;
  logic [CURV_W-1:0]            cv_rd_r;

  logic                         pt_we, lb_we, fl_we, cv_we;
  logic [ADDR_W-1:0]            pt_waddr, lb_waddr, fl_waddr, cv_waddr;
  logic [PT_W-1:0]              pt_wdata;
  label_t                       lb_wdata;
  logic                         fl_wdata;
  logic [CURV_W-1:0]            cv_wdata;

  // Shared multiplier, registered product.
  logic [MUL_W-1:0]             mul_a, mul_b;
  logic [PROD_W-1:0]            prod_r;

  // Combinational helpers.
  logic [COORD_BITS-1:0]        ax, ay, az;
  logic [3:0]                   tan_idx;
  logic [31:0]                  t2;
  logic [ELEV_W-1:0]            el_lhs, el_rhs;
  logic signed [1:0]            sa, sb;
  logic                         el_gt, el_lt;
  logic signed [DIFF_W-1:0]     dx, dy, dz;
  logic [GND_W-1:0]             g_lhs, g_rhs;
  logic                         is_ground;
  logic signed [SUM_W-1:0]      tx, ty, tz;
  logic [SUM_W-1:0]             msx, msy, msz;
  logic [CURV_W+1:0]            csum;
  logic [FILL_W-1:0]            min_fill_g, min_fill_d, fill_d;
  logic [FILL_W-1:0]            cidx;
  logic [RCNT_W-1:0]            ring_out;
  logic [RING_W-1:0]            r_lo, r_hi, dr_lo, dr_hi;
  logic                         in_acc, cfg_wr;

  assign in_acc = in_valid && !in_stall;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_point_class   = out_cls_r;
  assign out_ring          = out_ring_r;
  assign out_x_mm          = out_pt_r[PT_W-1 -: COORD_BITS];
  assign out_y_mm          = out_pt_r[2*COORD_BITS-1 -: COORD_BITS];
  assign out_z_mm          = out_pt_r[COORD_BITS-1:0];
  assign out_last_of_frame = out_last_r;
  assign out_dropped_points = out_drop_r;
  assign pready            = 1'b1;

  always_comb begin
    case (paddr[4:3])
      REG_EDGE:  prdata = 64'(edge_thr_r);
      REG_PLANE: prdata = 64'(plane_thr_r);
      REG_SLOPE: prdata = 64'(slope_r);
      default:   prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_thr_r  <= EDGE_RESET;
      plane_thr_r <= PLANE_RESET;
      slope_r     <= SLOPE_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_EDGE:  edge_thr_r  <= pwdata[CURV_W-1:0];
        REG_PLANE: plane_thr_r <= pwdata[CURV_W-1:0];
        REG_SLOPE: slope_r     <= pwdata[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (lb_we) lb_mem[lb_waddr] <= lb_wdata;
    if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
    if (cv_we) cv_mem[cv_waddr] <= cv_wdata;
    pd_r    <= pt_mem[rd_addr_r];
    lb_rd_r <= lb_mem[rd_addr_r];
    fl_rd_r <= fl_mem[rd_addr_r];
    cv_rd_r <= cv_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Magnitudes of the point being binned.
  assign ax = pt_x_r[COORD_BITS-1] ? COORD_BITS'(-pt_x_r) : COORD_BITS'(pt_x_r);
  assign ay = pt_y_r[COORD_BITS-1] ? COORD_BITS'(-pt_y_r) : COORD_BITS'(pt_y_r);
  assign az = pt_z_r[COORD_BITS-1] ? COORD_BITS'(-pt_z_r) : COORD_BITS'(pt_z_r);

  // Step 0 tests the lower edge of ring 0 at -18 degrees; step s tests 2s-16 degrees.
  always_comb begin
    if (step_r == '0) tan_idx = 4'd9;
    else if (step_r >= RCNT_W'(ZERO_STEP)) tan_idx = 4'(step_r - RCNT_W'(ZERO_STEP));
    else tan_idx = 4'(RCNT_W'(ZERO_STEP) - step_r);
  end
  assign t2 = tan_sq(tan_idx);

  // Elevation against the boundary: z*2^16 against r*tan, both sides squared.
  assign el_lhs = {az2_r, 32'd0};
  assign el_rhs = ELEV_W'(acc_r) + {prod_r[ELEV_W-33:0], 32'd0};

  always_comb begin
    sa = pt_z_r[COORD_BITS-1] ? -2'sd1 : ((pt_z_r != '0) ? 2'sd1 : 2'sd0);
    if (step_r == '0 || step_r < RCNT_W'(ZERO_STEP)) sb = -2'sd1;
    else if (step_r == RCNT_W'(ZERO_STEP)) sb = 2'sd0;
    else sb = 2'sd1;
    if (sa != sb) begin
      el_gt = (sa > sb);
      el_lt = !el_gt;
    end else if (sa == 2'sd1) begin
      el_gt = (el_lhs > el_rhs);
      el_lt = (el_lhs < el_rhs);
    end else if (sa == -2'sd1) begin
      el_gt = (el_lhs < el_rhs);
      el_lt = (el_lhs > el_rhs);
    end else begin
      el_gt = 1'b0;
      el_lt = 1'b0;
    end
  end

  // Ground pair: differences of the upper point (held) and the lower point (read).
  assign dx = DIFF_W'(hx_r) - DIFF_W'($signed(pd_r[PT_W-1 -: COORD_BITS]));
  assign dy = DIFF_W'(hy_r) - DIFF_W'($signed(pd_r[2*COORD_BITS-1 -: COORD_BITS]));
  assign dz = DIFF_W'(hz_r) - DIFF_W'($signed(pd_r[COORD_BITS-1:0]));
  assign g_lhs = GND_W'({mz2_r, 32'd0});
  assign g_rhs = GND_W'(acc_r) + GND_W'({prod_r, 32'd0});
  assign is_ground = (mz_r == '0) ? (slope_r != '0) : (g_lhs < g_rhs);

  // Curvature terms: the center point weighs minus six.
  always_comb begin
    tx = SUM_W'($signed(pd_r[PT_W-1 -: COORD_BITS]));
    ty = SUM_W'($signed(pd_r[2*COORD_BITS-1 -: COORD_BITS]));
    tz = SUM_W'($signed(pd_r[COORD_BITS-1:0]));
    if (k_r == 3'(CURV_SPAN)) begin
      tx = -((tx <<< 2) + (tx <<< 1));
      ty = -((ty <<< 2) + (ty <<< 1));
      tz = -((tz <<< 2) + (tz <<< 1));
    end
  end
  assign msx  = sx_r[SUM_W-1] ? SUM_W'(-sx_r) : SUM_W'(sx_r);
  assign msy  = sy_r[SUM_W-1] ? SUM_W'(-sy_r) : SUM_W'(sy_r);
  assign msz  = sz_r[SUM_W-1] ? SUM_W'(-sz_r) : SUM_W'(sz_r);
  assign csum = (CURV_W+2)'(acc_r) + (CURV_W+2)'(prod_r);
  assign cidx = FILL_W'(j_r + FILL_W'(k_r) - FILL_W'(CURV_SPAN));

  assign r_lo  = r_r[RING_W-1:0];
  assign r_hi  = RING_W'(r_r + 1'b1);
  assign dr_lo = dr_r[RING_W-1:0];
  assign dr_hi = RING_W'(dr_r + 1'b1);
  assign min_fill_g = (fill_r[r_lo] < fill_r[r_hi]) ? fill_r[r_lo] : fill_r[r_hi];
  assign min_fill_d = (fill_r[dr_lo] < fill_r[dr_hi]) ? fill_r[dr_lo] : fill_r[dr_hi];
  assign fill_d = fill_r[dr_lo];
  // A ground pair reports its upper point first.
  assign ring_out = (phase_r == PH_GROUND && !ph_r) ? RCNT_W'(dr_r + 1'b1) : dr_r;

  always_comb begin
    state_nxt      = state_r;
    pt_x_nxt       = pt_x_r;
    pt_y_nxt       = pt_y_r;
    pt_z_nxt       = pt_z_r;
    fe_nxt         = fe_r;
    acc_nxt        = acc_r;
    rsq_nxt        = rsq_r;
    az2_nxt        = az2_r;
    step_nxt       = step_r;
    drop_flag_nxt  = drop_flag_r;
    ring_nxt       = ring_r;
    fill_nxt       = fill_r;
    drop_cnt_nxt   = drop_cnt_r;
    closed_nxt     = closed_r;
    r_nxt          = r_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    hx_nxt         = hx_r;
    hy_nxt         = hy_r;
    hz_nxt         = hz_r;
    mx_nxt         = mx_r;
    my_nxt         = my_r;
    mz_nxt         = mz_r;
    h2_nxt         = h2_r;
    mz2_nxt        = mz2_r;
    g2_nxt         = g2_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    sz_nxt         = sz_r;
    phase_nxt      = phase_r;
    dr_nxt         = dr_r;
    di_nxt         = di_r;
    ph_nxt         = ph_r;
    seek_fetch_nxt = seek_fetch_r;
    res_cls_nxt    = res_cls_r;
    res_ring_nxt   = res_ring_r;
    res_pt_nxt     = res_pt_r;
    res_drop_nxt   = res_drop_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_cls_nxt    = out_cls_r;
    out_ring_nxt   = out_ring_r;
    out_pt_nxt     = out_pt_r;
    out_last_nxt   = out_last_r;
    out_drop_nxt   = out_drop_r;
    rd_addr_nxt    = rd_addr_r;
    mul_a          = '0;
    mul_b          = '0;
    pt_we          = 1'b0;
    pt_waddr       = {ring_r, fill_r[ring_r][IDX_W-1:0]};
    pt_wdata       = {pt_x_r, pt_y_r, pt_z_r};
    lb_we          = 1'b0;
    lb_waddr       = rd_addr_r;
    lb_wdata       = LBL_FREE;
    fl_we          = 1'b0;
    fl_waddr       = rd_addr_r;
    fl_wdata       = 1'b0;
    cv_we          = 1'b0;
    cv_waddr       = {r_lo, j_r[IDX_W-1:0]};
    cv_wdata       = (csum > (CURV_W+2)'({CURV_W{1'b1}})) ? {CURV_W{1'b1}}
                                                          : csum[CURV_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_op) begin
            // A load after a closed frame opens a new frame.
            if (closed_r) begin
              for (int i = 0; i < RINGS; i++) fill_nxt[i] = '0;
              drop_cnt_nxt = '0;
              phase_nxt    = PH_NONE;
              dr_nxt       = '0;
              di_nxt       = '0;
              ph_nxt       = 1'b0;
              closed_nxt   = 1'b0;
            end
            pt_x_nxt  = in_x_mm;
            pt_y_nxt  = in_y_mm;
            pt_z_nxt  = in_z_mm;
            fe_nxt    = in_frame_end;
            state_nxt = ST_EL_X;
          end else if (phase_r != PH_NONE) begin
            res_cls_nxt  = 2'(phase_r - 1'b1);
            res_ring_nxt = ring_out[RING_W-1:0];
            rd_addr_nxt  = {ring_out[RING_W-1:0], di_r[IDX_W-1:0]};
            state_nxt    = ST_F_B;
          end
        end
      end

      ST_EL_X: begin
        mul_a     = MUL_W'(ax);
        mul_b     = MUL_W'(ax);
        state_nxt = ST_EL_Y;
      end
      ST_EL_Y: begin
        acc_nxt   = prod_r;
        mul_a     = MUL_W'(ay);
        mul_b     = MUL_W'(ay);
        state_nxt = ST_EL_Z;
      end
      ST_EL_Z: begin
        rsq_nxt   = RSQ_W'(acc_r + prod_r);
        mul_a     = MUL_W'(az);
        mul_b     = MUL_W'(az);
        step_nxt  = '0;
        state_nxt = ST_EL_LO;
      end
      ST_EL_LO: begin
        if (step_r == '0) az2_nxt = RSQ_W'(prod_r);
        mul_a     = rsq_r[31:0];
        mul_b     = t2;
        state_nxt = ST_EL_HI;
      end
      ST_EL_HI: begin
        acc_nxt   = prod_r;
        mul_a     = MUL_W'(rsq_r[RSQ_W-1:32]);
        mul_b     = t2;
        state_nxt = ST_EL_CMP;
      end
      ST_EL_CMP: begin
        if (step_r == '0) begin
          if (!el_gt) begin
            drop_flag_nxt = 1'b1;
            state_nxt     = ST_LD_FIN;
          end else begin
            step_nxt  = RCNT_W'(1);
            state_nxt = ST_EL_LO;
          end
        end else if (el_lt) begin
          ring_nxt      = RING_W'(step_r - 1'b1);
          drop_flag_nxt = 1'b0;
          state_nxt     = ST_LD_FIN;
        end else if (step_r == RCNT_W'(RINGS)) begin
          drop_flag_nxt = 1'b1;
          state_nxt     = ST_LD_FIN;
        end else begin
          step_nxt  = RCNT_W'(step_r + 1'b1);
          state_nxt = ST_EL_LO;
        end
      end
      ST_LD_FIN: begin
        if (drop_flag_r || fill_r[ring_r] >= FILL_W'(PTS_PER_RING)) begin
          if (drop_cnt_r != {DROP_W{1'b1}}) drop_cnt_nxt = DROP_W'(drop_cnt_r + 1'b1);
        end else begin
          pt_we            = 1'b1;
          fill_nxt[ring_r] = FILL_W'(fill_r[ring_r] + 1'b1);
        end
        if (fe_r) begin
          r_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_CLR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      // Clear labels and pair flags of every stored point.
      ST_CLR: begin
        if (r_r == RCNT_W'(RINGS)) begin
          r_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_G_A;
        end else if (j_r >= fill_r[r_lo]) begin
          r_nxt = RCNT_W'(r_r + 1'b1);
          j_nxt = '0;
        end else begin
          lb_we    = 1'b1;
          lb_waddr = {r_lo, j_r[IDX_W-1:0]};
          lb_wdata = LBL_FREE;
          fl_we    = 1'b1;
          fl_waddr = {r_lo, j_r[IDX_W-1:0]};
          fl_wdata = 1'b0;
          j_nxt    = FILL_W'(j_r + 1'b1);
        end
      end

      // Ground pass over same-index points of neighboring low rings.
      ST_G_A: begin
        if (r_r == RCNT_W'(PAIRS)) begin
          r_nxt     = '0;
          j_nxt     = FILL_W'(CURV_SPAN);
          state_nxt = ST_C_CHK;
        end else if (j_r >= min_fill_g) begin
          r_nxt = RCNT_W'(r_r + 1'b1);
          j_nxt = '0;
        end else begin
          rd_addr_nxt = {r_hi, j_r[IDX_W-1:0]};
          state_nxt   = ST_G_B;
        end
      end
      ST_G_B: begin
        rd_addr_nxt = {r_lo, j_r[IDX_W-1:0]};
        state_nxt   = ST_G_C;
      end
      ST_G_C: begin
        hx_nxt    = $signed(pd_r[PT_W-1 -: COORD_BITS]);
        hy_nxt    = $signed(pd_r[2*COORD_BITS-1 -: COORD_BITS]);
        hz_nxt    = $signed(pd_r[COORD_BITS-1:0]);
        state_nxt = ST_G_D;
      end
      ST_G_D: begin
        mx_nxt    = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        my_nxt    = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        mz_nxt    = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
        state_nxt = ST_G_MX;
      end
      ST_G_MX: begin
        mul_a     = MUL_W'(mx_r);
        mul_b     = MUL_W'(mx_r);
        state_nxt = ST_G_MY;
      end
      ST_G_MY: begin
        acc_nxt   = prod_r;
        mul_a     = MUL_W'(my_r);
        mul_b     = MUL_W'(my_r);
        state_nxt = ST_G_MZ;
      end
      ST_G_MZ: begin
        h2_nxt    = (2*DIFF_W)'(acc_r + prod_r);
        mul_a     = MUL_W'(mz_r);
        mul_b     = MUL_W'(mz_r);
        state_nxt = ST_G_GG;
      end
      ST_G_GG: begin
        mz2_nxt   = (2*DIFF_W)'(prod_r);
        mul_a     = MUL_W'(slope_r);
        mul_b     = MUL_W'(slope_r);
        state_nxt = ST_G_H1;
      end
      ST_G_H1: begin
        g2_nxt    = prod_r[31:0];
        mul_a     = h2_r[31:0];
        mul_b     = prod_r[31:0];
        state_nxt = ST_G_H2;
      end
      ST_G_H2: begin
        acc_nxt   = prod_r;
        mul_a     = MUL_W'(h2_r[2*DIFF_W-1:32]);
        mul_b     = g2_r;
        state_nxt = ST_G_CMP;
      end
      ST_G_CMP: begin
        if (is_ground) begin
          fl_we     = 1'b1;
          fl_wdata  = 1'b1;
          lb_we     = 1'b1;
          lb_wdata  = LBL_GROUND;
          state_nxt = ST_G_W2;
        end else begin
          j_nxt     = FILL_W'(j_r + 1'b1);
          state_nxt = ST_G_A;
        end
      end
      ST_G_W2: begin
        lb_we     = 1'b1;
        lb_waddr  = {r_hi, j_r[IDX_W-1:0]};
        lb_wdata  = LBL_GROUND;
        j_nxt     = FILL_W'(j_r + 1'b1);
        state_nxt = ST_G_A;
      end

      // Curvature pass: seven-point sum around each inner point.
      ST_C_CHK: begin
        if (r_r == RCNT_W'(RINGS)) begin
          r_nxt     = '0;
          j_nxt     = FILL_W'(PICK_SKIP);
          state_nxt = ST_S_A;
        end else if ((FILL_W+1)'(j_r) + (FILL_W+1)'(CURV_SPAN) >= (FILL_W+1)'(fill_r[r_lo])) begin
          r_nxt = RCNT_W'(r_r + 1'b1);
          j_nxt = FILL_W'(CURV_SPAN);
        end else begin
          k_nxt     = '0;
          sx_nxt    = '0;
          sy_nxt    = '0;
          sz_nxt    = '0;
          state_nxt = ST_C_A;
        end
      end
      ST_C_A: begin
        rd_addr_nxt = {r_lo, cidx[IDX_W-1:0]};
        state_nxt   = ST_C_B;
      end
      ST_C_B: begin
        state_nxt = ST_C_C;
      end
      ST_C_C: begin
        sx_nxt = sx_r + tx;
        sy_nxt = sy_r + ty;
        sz_nxt = sz_r + tz;
        if (k_r == 3'(2*CURV_SPAN)) begin
          state_nxt = ST_C_SX;
        end else begin
          k_nxt     = 3'(k_r + 1'b1);
          state_nxt = ST_C_A;
        end
      end
      ST_C_SX: begin
        mul_a     = MUL_W'(msx);
        mul_b     = MUL_W'(msx);
        state_nxt = ST_C_SY;
      end
      ST_C_SY: begin
        acc_nxt   = prod_r;
        mul_a     = MUL_W'(msy);
        mul_b     = MUL_W'(msy);
        state_nxt = ST_C_SZ;
      end
      ST_C_SZ: begin
        acc_nxt   = acc_r + prod_r;
        mul_a     = MUL_W'(msz);
        mul_b     = MUL_W'(msz);
        state_nxt = ST_C_W;
      end
      ST_C_W: begin
        cv_we     = 1'b1;
        j_nxt     = FILL_W'(j_r + 1'b1);
        state_nxt = ST_C_CHK;
      end

      // Selection pass: edge or plane among unmarked points, skip after a pick.
      ST_S_A: begin
        if (r_r == RCNT_W'(RINGS)) begin
          closed_nxt     = 1'b1;
          phase_nxt      = PH_GROUND;
          dr_nxt         = '0;
          di_nxt         = '0;
          ph_nxt         = 1'b0;
          seek_fetch_nxt = 1'b0;
          state_nxt      = ST_SK_A;
        end else if ((FILL_W+1)'(j_r) + (FILL_W+1)'(PICK_SKIP) >= (FILL_W+1)'(fill_r[r_lo])) begin
          r_nxt = RCNT_W'(r_r + 1'b1);
          j_nxt = FILL_W'(PICK_SKIP);
        end else begin
          rd_addr_nxt = {r_lo, j_r[IDX_W-1:0]};
          state_nxt   = ST_S_B;
        end
      end
      ST_S_B: begin
        state_nxt = ST_S_C;
      end
      ST_S_C: begin
        state_nxt = ST_S_A;
        j_nxt     = FILL_W'(j_r + 1'b1);
        if (lb_rd_r == LBL_FREE) begin
          if (cv_rd_r > edge_thr_r) begin
            lb_we    = 1'b1;
            lb_wdata = LBL_EDGE;
            j_nxt    = FILL_W'(j_r + FILL_W'(PICK_SKIP + 1));
          end else if (cv_rd_r < plane_thr_r) begin
            lb_we    = 1'b1;
            lb_wdata = LBL_PLANE;
            j_nxt    = FILL_W'(j_r + FILL_W'(PICK_SKIP + 1));
          end
        end
      end

      // Search forward, inclusive, for the next result to drain.
      ST_SK_A: begin
        case (phase_r)
          PH_NONE: begin
            state_nxt = seek_fetch_r ? ST_EMIT : ST_IDLE;
          end
          PH_GROUND: begin
            if (dr_r >= RCNT_W'(PAIRS)) begin
              phase_nxt = PH_EDGE;
              dr_nxt    = '0;
              di_nxt    = '0;
            end else if (di_r >= min_fill_d) begin
              dr_nxt = RCNT_W'(dr_r + 1'b1);
              di_nxt = '0;
            end else begin
              rd_addr_nxt = {dr_lo, di_r[IDX_W-1:0]};
              state_nxt   = ST_SK_B;
            end
          end
          default: begin
            if (dr_r >= RCNT_W'(RINGS)) begin
              phase_nxt = (phase_r == PH_EDGE) ? PH_PLANE : PH_NONE;
              dr_nxt    = '0;
              di_nxt    = '0;
            end else if (di_r >= fill_d) begin
              dr_nxt = RCNT_W'(dr_r + 1'b1);
              di_nxt = '0;
            end else begin
              rd_addr_nxt = {dr_lo, di_r[IDX_W-1:0]};
              state_nxt   = ST_SK_B;
            end
          end
        endcase
      end
      ST_SK_B: begin
        state_nxt = ST_SK_C;
      end
      ST_SK_C: begin
        if ((phase_r == PH_GROUND && fl_rd_r) ||
            (phase_r == PH_EDGE && lb_rd_r == LBL_EDGE) ||
            (phase_r == PH_PLANE && lb_rd_r == LBL_PLANE)) begin
          state_nxt = seek_fetch_r ? ST_EMIT : ST_IDLE;
        end else begin
          di_nxt    = FILL_W'(di_r + 1'b1);
          state_nxt = ST_SK_A;
        end
      end

      // Fetch: read the point at the drain position, then advance.
      ST_F_B: begin
        state_nxt = ST_F_C;
      end
      ST_F_C: begin
        res_pt_nxt   = pd_r;
        res_drop_nxt = drop_cnt_r;
        if (phase_r == PH_GROUND && !ph_r) begin
          ph_nxt    = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          ph_nxt         = 1'b0;
          di_nxt         = FILL_W'(di_r + 1'b1);
          seek_fetch_nxt = 1'b1;
          state_nxt      = ST_SK_A;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cls_nxt   = res_cls_r;
          out_ring_nxt  = res_ring_r;
          out_pt_nxt    = res_pt_r;
          out_drop_nxt  = res_drop_r;
          out_last_nxt  = (phase_r == PH_NONE);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      for (int i = 0; i < RINGS; i++) fill_r[i] <= '0;
      drop_cnt_r   <= '0;
      closed_r     <= 1'b0;
      phase_r      <= PH_NONE;
      dr_r         <= '0;
      di_r         <= '0;
      ph_r         <= 1'b0;
      seek_fetch_r <= 1'b0;
      out_valid_r  <= 1'b0;
      r_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      step_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      drop_cnt_r   <= drop_cnt_nxt;
      closed_r     <= closed_nxt;
      phase_r      <= phase_nxt;
      dr_r         <= dr_nxt;
      di_r         <= di_nxt;
      ph_r         <= ph_nxt;
      seek_fetch_r <= seek_fetch_nxt;
      out_valid_r  <= out_valid_nxt;
      r_r          <= r_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      step_r       <= step_nxt;
    end
    pt_x_r      <= pt_x_nxt;
    pt_y_r      <= pt_y_nxt;
    pt_z_r      <= pt_z_nxt;
    fe_r        <= fe_nxt;
    acc_r       <= acc_nxt;
    rsq_r       <= rsq_nxt;
    az2_r       <= az2_nxt;
    drop_flag_r <= drop_flag_nxt;
    ring_r      <= ring_nxt;
    hx_r        <= hx_nxt;
    hy_r        <= hy_nxt;
    hz_r        <= hz_nxt;
    mx_r        <= mx_nxt;
    my_r        <= my_nxt;
    mz_r        <= mz_nxt;
    h2_r        <= h2_nxt;
    mz2_r       <= mz2_nxt;
    g2_r        <= g2_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    sz_r        <= sz_nxt;
    rd_addr_r   <= rd_addr_nxt;
    res_cls_r   <= res_cls_nxt;
    res_ring_r  <= res_ring_nxt;
    res_pt_r    <= res_pt_nxt;
    res_drop_r  <= res_drop_nxt;
    out_cls_r   <= out_cls_nxt;
    out_ring_r  <= out_ring_nxt;
    out_pt_r    <= out_pt_nxt;
    out_last_r  <= out_last_nxt;
    out_drop_r  <= out_drop_nxt;
  end

endmodule

`default_nettype wire

// ----- test/tb_lidar_ring_feature_extractor.sv -----
// Self-checking testbench of lidar_ring_feature_extractor: loads lidar frames,
// fetches the classified points and checks each one against a built-in predictor.
// Depends on lrfe_pkg and on the lidar_ring_feature_extractor RTL.
`timescale 1ns / 1ps

module tb_lidar_ring_feature_extractor;
  import lrfe_pkg::*;

  localparam bit OP_LOAD  = 1'b0;
  localparam bit OP_FETCH = 1'b1;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam real DEG = 3.14159265358979 / 180.0;
  // round(tan(2n degrees) * 2^16) for the ring boundaries, n = 0 .. 9.
  localparam longint unsigned TAN_Q16 [10] = '{0, 2289, 4583, 6888, 9210, 11556,
                                                13930, 16340, 18792, 21294};

  typedef struct {
    bit                    op;
    logic signed [19:0]    x, y, z;
    bit                    fe;
  } scan_item_t;

  typedef struct {
    logic [1:0]         cls;
    logic [3:0]         ring;
    logic signed [19:0] x, y, z;
    bit                 last;
    logic [15:0]        drops;
  } feature_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_op = 1'b0, in_frame_end = 1'b0;
  logic signed [COORD_BITS-1:0] in_x_mm = '0, in_y_mm = '0, in_z_mm = '0;
  logic out_stall = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  wire in_stall, out_valid, out_last_of_frame, pready;
  wire [1:0] out_point_class;
  wire [RING_W-1:0] out_ring;
  wire signed [COORD_BITS-1:0] out_x_mm, out_y_mm, out_z_mm;
  wire [DROP_W-1:0] out_dropped_points;
  wire [63:0] prdata;

  lidar_ring_feature_extractor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_x_mm(in_x_mm), .in_y_mm(in_y_mm), .in_z_mm(in_z_mm),
    .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_class(out_point_class), .out_ring(out_ring),
    .out_x_mm(out_x_mm), .out_y_mm(out_y_mm), .out_z_mm(out_z_mm),
    .out_last_of_frame(out_last_of_frame), .out_dropped_points(out_dropped_points),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Stimulus waiting to be driven, and the classified points still owed by the block.
  scan_item_t points_to_send[$];
  feature_t   features_due[$];
  scan_item_t cur_item;
  int  sender_idle_pct = 0;
  int  rcv_stall_pct = 0;
  bit  hold_sender = 1'b0;
  int  errors = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the point store, labels and drain position.
  // ---------------------------------------------------------------------------
  logic signed [19:0] st_x [STORE_DEPTH];
  logic signed [19:0] st_y [STORE_DEPTH];
  logic signed [19:0] st_z [STORE_DEPTH];
  label_t             st_lbl [STORE_DEPTH];
  bit                 st_pair [STORE_DEPTH];
  logic [47:0]        st_curv [STORE_DEPTH];
  int                 fill [RINGS];
  logic [1:0]         dr_phase = PH_NONE;
  int                 dr_ring = 0, dr_idx = 0;
  bit                 dr_half = 1'b0;
  int                 drops = 0;
  bit                 frame_closed = 1'b0;
  logic [47:0]        edge_thr = 48'd200000, plane_thr = 48'd100000;
  logic [15:0]        slope_tan = 16'd11556;

  // Sign of (elevation - b degrees), with both sides squared to stay exact.
  function automatic int elev_vs(longint z, longint unsigned rsq, int b);
    longint unsigned t, az;
    logic [127:0] lhs, rhs;
    int sa, sb, c, ang;
    if (rsq == 0) begin
      ang = z > 0 ? 90 : (z < 0 ? -90 : 0);
      return ang > b ? 1 : (ang < b ? -1 : 0);
    end
    t = TAN_Q16[(b < 0 ? -b : b) / 2];
    az = z < 0 ? -z : z;
    lhs = 128'(az * az) << 32;
    rhs = 128'(rsq) * 128'(t * t);
    sa = z > 0 ? 1 : (z < 0 ? -1 : 0);
    sb = b > 0 ? 1 : (b < 0 ? -1 : 0);
    if (sa != sb) return sa > sb ? 1 : -1;
    c = lhs < rhs ? -1 : (lhs > rhs ? 1 : 0);
    return sa > 0 ? c : (sa < 0 ? -c : 0);
  endfunction

  function automatic int elevation_ring(longint x, longint y, longint z);
    longint unsigned rsq;
    rsq = x * x + y * y;
    if (elev_vs(z, rsq, -18) <= 0) return -1;
    for (int k = 1; k <= RINGS; k++)
      if (elev_vs(z, rsq, -16 + 2 * k) < 0) return k - 1;
    return -1;
  endfunction

  function automatic bit pair_is_ground(int a, int b);
    longint dx, dy, dz;
    longint unsigned mx, my, mz;
    logic [127:0] h2, lhs, rhs;
    dx = longint'(st_x[a]) - st_x[b];
    dy = longint'(st_y[a]) - st_y[b];
    dz = longint'(st_z[a]) - st_z[b];
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    mz = dz < 0 ? -dz : dz;
    if (mz == 0) return slope_tan != 0;
    h2 = 128'(mx * mx) + 128'(my * my);
    lhs = 128'(mz * mz) << 32;
    rhs = h2 * 128'(slope_tan) * 128'(slope_tan);
    return lhs < rhs;
  endfunction

  function automatic longint unsigned sq_sat(longint d);
    longint unsigned m;
    m = d < 0 ? -d : d;
    return m >= (64'd1 << 24) ? 64'(MAX48) : m * m;
  endfunction

  // Clearing, ground, curvature and selection passes over the frame just closed.
  function automatic void run_frame_passes();
    int n, j, base, lo, hi, i;
    longint sx, sy, sz, w;
    longint unsigned c;
    for (int r = 0; r < RINGS; r++)
      for (j = 0; j < fill[r]; j++) begin
        st_lbl[r * PTS_PER_RING + j] = LBL_FREE;
        st_pair[r * PTS_PER_RING + j] = 1'b0;
      end
    for (int r = 0; r < PAIRS; r++) begin
      n = fill[r] < fill[r + 1] ? fill[r] : fill[r + 1];
      for (j = 0; j < n; j++) begin
        lo = r * PTS_PER_RING + j;
        hi = lo + PTS_PER_RING;
        if (pair_is_ground(hi, lo)) begin
          st_pair[lo] = 1'b1;
          st_lbl[lo] = LBL_GROUND;
          st_lbl[hi] = LBL_GROUND;
        end
      end
    end
    for (int r = 0; r < RINGS; r++) begin
      n = fill[r];
      base = r * PTS_PER_RING;
      for (j = CURV_SPAN; j < n - CURV_SPAN; j++) begin
        sx = 0; sy = 0; sz = 0;
        for (int k = -CURV_SPAN; k <= CURV_SPAN; k++) begin
          i = base + j + k;
          w = (k == 0) ? -6 : 1;
          sx += w * st_x[i];
          sy += w * st_y[i];
          sz += w * st_z[i];
        end
        c = sq_sat(sx) + sq_sat(sy) + sq_sat(sz);
        st_curv[base + j] = c > MAX48 ? MAX48 : c[47:0];
      end
      // Picks are spaced: five points are passed over after each edge or plane.
      j = PICK_SKIP;
      while (j < n - PICK_SKIP) begin
        i = base + j;
        if (st_lbl[i] == LBL_FREE && st_curv[i] > edge_thr) begin
          st_lbl[i] = LBL_EDGE;
          j += PICK_SKIP + 1;
        end else if (st_lbl[i] == LBL_FREE && st_curv[i] < plane_thr) begin
          st_lbl[i] = LBL_PLANE;
          j += PICK_SKIP + 1;
        end else begin
          j++;
        end
      end
    end
  endfunction

  // Advance the drain position to the next reportable point, inclusive.
  function automatic void seek_next_feature();
    int n;
    label_t want;
    while (dr_phase != PH_NONE) begin
      if (dr_phase == PH_GROUND) begin
        if (dr_ring >= PAIRS) begin
          dr_phase = PH_EDGE; dr_ring = 0; dr_idx = 0;
        end else begin
          n = fill[dr_ring] < fill[dr_ring + 1] ? fill[dr_ring] : fill[dr_ring + 1];
          if (dr_idx >= n) begin
            dr_ring++; dr_idx = 0;
          end else if (st_pair[dr_ring * PTS_PER_RING + dr_idx]) begin
            return;
          end else begin
            dr_idx++;
          end
        end
      end else begin
        want = (dr_phase == PH_EDGE) ? LBL_EDGE : LBL_PLANE;
        if (dr_ring >= RINGS) begin
          dr_phase = (dr_phase == PH_EDGE) ? PH_PLANE : PH_NONE;
          dr_ring = 0; dr_idx = 0;
        end else if (dr_idx >= fill[dr_ring]) begin
          dr_ring++; dr_idx = 0;
        end else if (st_lbl[dr_ring * PTS_PER_RING + dr_idx] == want) begin
          return;
        end else begin
          dr_idx++;
        end
      end
    end
  endfunction

  function automatic void load_point(scan_item_t it);
    int rg, i;
    if (frame_closed) begin
      foreach (fill[r]) fill[r] = 0;
      drops = 0;
      dr_phase = PH_NONE; dr_ring = 0; dr_idx = 0; dr_half = 1'b0;
      frame_closed = 1'b0;
    end
    rg = elevation_ring(it.x, it.y, it.z);
    if (rg < 0 || fill[rg] >= PTS_PER_RING) begin
      if (drops < 65535) drops++;
    end else begin
      i = rg * PTS_PER_RING + fill[rg];
      st_x[i] = it.x; st_y[i] = it.y; st_z[i] = it.z;
      fill[rg]++;
    end
    if (it.fe) begin
      run_frame_passes();
      frame_closed = 1'b1;
      dr_phase = PH_GROUND; dr_ring = 0; dr_idx = 0; dr_half = 1'b0;
      seek_next_feature();
    end
  endfunction

  // A ground pair is reported upper ring first, then lower ring.
  function automatic bit fetch_feature(output feature_t f);
    int rg, i;
    f = '{default: '0};
    if (dr_phase == PH_NONE) return 1'b0;
    f.cls = dr_phase - 2'd1;
    rg = (dr_phase == PH_GROUND && !dr_half) ? dr_ring + 1 : dr_ring;
    i = rg * PTS_PER_RING + dr_idx;
    f.ring = rg[3:0];
    f.x = st_x[i]; f.y = st_y[i]; f.z = st_z[i];
    f.drops = drops[15:0];
    if (dr_phase == PH_GROUND && !dr_half) begin
      dr_half = 1'b1;
    end else begin
      dr_half = 1'b0;
      dr_idx++;
      seek_next_feature();
    end
    f.last = (dr_phase == PH_NONE);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items; an accepted item is fed to the predictor.
  // The payload only moves when the current item was taken or none is shown.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    feature_t f;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_item.op == OP_LOAD) load_point(cur_item);
        else if (fetch_feature(f)) features_due.push_back(f);
      end
      if (!in_valid || !in_stall) begin
        if (points_to_send.size() > 0 && !hold_sender &&
            $urandom_range(99) >= sender_idle_pct) begin
          cur_item = points_to_send.pop_front();
          in_valid <= 1'b1;
          in_op <= cur_item.op;
          in_x_mm <= cur_item.x;
          in_y_mm <= cur_item.y;
          in_z_mm <= cur_item.z;
          in_frame_end <= cur_item.fe;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls on the result side, field-by-field comparison.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    feature_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (features_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual ring %0d x %0d",
                   $time, out_ring, out_x_mm);
          errors++;
        end else begin
          e = features_due.pop_front();
          check_field("point_class", e.cls, out_point_class);
          check_field("ring", e.ring, out_ring);
          check_field("x_mm", e.x, out_x_mm);
          check_field("y_mm", e.y, out_y_mm);
          check_field("z_mm", e.z, out_z_mm);
          check_field("last_of_frame", e.last, out_last_of_frame);
          check_field("dropped_points", e.drops, out_dropped_points);
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic add_item(bit op, int x, int y, int z, bit fe);
    scan_item_t it;
    it.op = op; it.x = 20'(x); it.y = 20'(y); it.z = 20'(z); it.fe = fe;
    points_to_send.push_back(it);
  endtask

  function automatic int to_coord(real v);
    if (v > 524287.0) return 524287;
    if (v < -524288.0) return -524288;
    return $rtoi(v);
  endfunction

  // One point of a scan column. Flat columns keep z near one depth below the horizon,
  // so same-index points of low rings lie on level ground; others follow a ring radius.
  task automatic add_scan_point(int r, int j, bit flat, real hgt, real rad, bit fe);
    real el, rng, a, z;
    int d;
    d = $urandom_range(0, 1600);
    el = 2.0 * r - 15.0 + (d - 800) / 1000.0;
    a = j * 0.004 + 0.3 * r;
    if (flat && el < -0.5) begin
      if ($urandom_range(3) == 0) hgt = hgt + $urandom_range(0, 60);
      rng = hgt / $tan(-el * DEG);
      z = -hgt;
    end else begin
      rng = rad + $urandom_range(0, 30);
      if ($urandom_range(9) == 0) rng = rng * 1.8;
      z = rng * $tan(el * DEG);
    end
    add_item(OP_LOAD, to_coord(rng * $cos(a)), to_coord(rng * $sin(a)), to_coord(z), fe);
  endtask

  task automatic add_noise_item();
    add_item($urandom_range(1), 20'($urandom), 20'($urandom), 20'($urandom),
             $urandom_range(19) == 0);
  endtask

  // A frame over a few neighbouring rings, usually starting at the ground rings,
  // then a run of fetches that mostly drains it and sometimes stops short.
  task automatic add_frame();
    int r0, nr, maxn, total, nfetch;
    int cnt [RINGS];
    real rad [RINGS];
    bit flat;
    real hgt;
    r0 = ($urandom_range(3) == 0) ? $urandom_range(0, 14) : 0;
    nr = $urandom_range(2, 6);
    if (r0 + nr > RINGS) nr = RINGS - r0;
    flat = $urandom_range(1);
    hgt = 800 + $urandom_range(0, 2500);
    maxn = 0;
    total = 0;
    for (int r = 0; r < RINGS; r++) begin
      cnt[r] = $urandom_range(8, 22);
      rad[r] = 1500 + $urandom_range(0, 30000);
      if (cnt[r] > maxn) maxn = cnt[r];
    end
    for (int j = 0; j < maxn; j++)
      for (int r = r0; r < r0 + nr; r++)
        if (j < cnt[r]) begin
          if ($urandom_range(24) == 0) add_item(OP_LOAD, 20'($urandom), 20'($urandom),
                                                20'($urandom), 1'b0);
          add_scan_point(r, j, flat, hgt, rad[r], 1'b0);
          total++;
        end
    add_scan_point(r0, maxn, flat, hgt, rad[r0], 1'b1);
    nfetch = ($urandom_range(4) == 0) ? $urandom_range(0, total / 2) : 2 * total + 4;
    for (int k = 0; k < nfetch; k++)
      add_item(OP_FETCH, 20'($urandom), 20'($urandom), 20'($urandom), $urandom_range(1));
  endtask

  // The block is idle once all items are taken, every result is in and the
  // last item, which may be a frame end with no result, has finished.
  task automatic wait_idle();
    while (points_to_send.size() != 0 || in_valid || features_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_EDGE:  edge_thr = value[47:0];
      REG_PLANE: plane_thr = value[47:0];
      REG_SLOPE: slope_tan = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(logic [63:0] edge_v, logic [63:0] plane_v,
                                logic [63:0] slope_v);
    wait_idle();
    cfg_write(REG_EDGE, edge_v);
    cfg_write(REG_PLANE, plane_v);
    cfg_write(REG_SLOPE, slope_v);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int phase_items;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a fetch with nothing to drain, coordinate extremes, points
    // straight up, down and at the origin, the low ring edge, and a small flat
    // patch over rings 0 to 2 that forms ground pairs.
    sender_idle_pct = 14;
    rcv_stall_pct = 67;
    add_item(OP_FETCH, 0, 0, 0, 1'b0);
    add_item(OP_LOAD, -524288, -524288, -524288, 1'b0);
    add_item(OP_LOAD, 524287, 524287, 524287, 1'b0);
    add_item(OP_LOAD, 0, 0, 0, 1'b0);
    add_item(OP_LOAD, 0, 0, 1, 1'b0);
    add_item(OP_LOAD, 0, 0, -1, 1'b0);
    add_item(OP_LOAD, 524287, 0, 0, 1'b0);
    add_item(OP_LOAD, -524288, 0, -1, 1'b0);
    add_item(OP_LOAD, 1000, 0, -325, 1'b0);
    for (int j = 0; j < 3; j++)
      for (int r = 0; r < 3; r++)
        add_scan_point(r, j, 1'b1, 1700.0, 5000.0, (j == 2 && r == 2));
    for (int k = 0; k < 7; k++) add_item(OP_FETCH, 0, 0, 0, 1'b0);

    // Random phases, each under its own thresholds and one of three idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_thresholds(64'd200000, 64'd100000, 64'd11556);
        // High bits beyond the register width must be dropped.
        1: set_thresholds(64'hFFFF_0000_0000_0000, {16'hFFFF, MAX48}, 64'hFFFF_0000);
        2: set_thresholds({16'h0, MAX48}, 64'd0, 64'd65535);
        3: set_thresholds(64'd150000, 64'd150000, 64'd5000);
        4: set_thresholds($urandom_range(0, 2000000), $urandom_range(0, 2000000),
                          $urandom_range(0, 65535));
        default: set_thresholds({16'h0, MAX48}, {16'h0, MAX48}, 64'd30000);
      endcase
      sender_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 67 : 0;
      rcv_stall_pct = (ph < 2) ? 67 : (ph < 4) ? 14 : 0;
      phase_items = 0;
      while (phase_items < 250) begin
        int before_n;
        before_n = points_to_send.size();
        if ($urandom_range(5) == 0) begin
          for (int k = 0; k < 6; k++) add_noise_item();
        end else begin
          add_frame();
        end
        phase_items += points_to_send.size() - before_n;
      end
      if (ph == 3) begin
        while (points_to_send.size() > phase_items / 2) @(posedge clk);
        hold_sender = 1'b1;
        while (features_due.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
    end

    // A frame that overfills one ring: the surplus points are dropped.
    wait_idle();
    cfg_write(REG_EDGE, 64'd200000);
    for (int k = 0; k < PTS_PER_RING + 2; k++)
      add_item(OP_LOAD, $urandom_range(1, 524287), 20'($urandom), 0,
               k == PTS_PER_RING + 1);
    for (int k = 0; k < 360; k++) add_item(OP_FETCH, 0, 0, 0, 1'b0);

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0 && features_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0t: %0d errors, %0d results never arrived", $time, errors,
               features_due.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("%0t: timeout", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lrfe_pkg.sv
sv/lidar_ring_feature_extractor.sv
test/tb_lidar_ring_feature_extractor.sv
